>>> rtl/core/phfc_pkg.sv
// Shared types and constants for the packet header parser with flow counter.
// No dependencies.
package phfc_pkg;

    localparam int TABLE_DEPTH  = 64;
    localparam int HEADER_BYTES = 64;
    localparam int TIDX_W       = $clog2(TABLE_DEPTH);
    localparam int TCNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W        = 11;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_TCP   = 8'd6;
    localparam logic [7:0]  IP_UDP   = 8'd17;
    localparam logic [7:0]  IP_ICMP  = 8'd1;
    localparam logic [7:0]  IP_IGMP  = 8'd2;

    localparam logic [2:0] CLS_NONIP = 3'd0;
    localparam logic [2:0] CLS_TCP   = 3'd1;
    localparam logic [2:0] CLS_UDP   = 3'd2;
    localparam logic [2:0] CLS_ICMP  = 3'd3;
    localparam logic [2:0] CLS_IGMP  = 3'd4;
    localparam logic [2:0] CLS_OTHER = 3'd5;

    typedef struct packed {
        logic [47:0]      dmac;
        logic [47:0]      smac;
        logic [15:0]      ethertype;
        logic [3:0]       ihl;
        logic [7:0]       proto;
        logic [31:0]      saddr;
        logic [31:0]      daddr;
        logic [15:0]      sport;
        logic [15:0]      dport;
        logic [POS_W-1:0] pos;
    } hdr_t;

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [2:0]  proto_class;
        logic [31:0] pair_count;
        logic        table_full;
        logic        truncated;
        logic        entry_valid;
    } rec_t;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] tally;
    } pair_t;

endpackage

>>> rtl/core/packet_header_parser_flow_counter_top.sv
// Top level: header parse, address-pair table search/update, output register.
// Depends on phfc_pkg, phfc_hdr_capture, phfc_pair_ram.
//
// Input channel (in_valid/in_stall) carries one item per transfer:
// operation 0 is a frame byte, operation 1 reads pair table slot entry_index.
// Frame bytes that are not last are taken one per cycle while idle and give no result.
// The last byte of a frame gives one record; a read gives one table entry.
// A read passes through S_RDD and S_DONE to the output register. A last
// byte passes through S_EVAL and S_DONE for non-IPv4 or short frames; an
// IPv4 record searches the pair table entry by entry, each entry taking
// one memory read (S_LOOK) and one compare (S_CMP), and stops early on a
// match. The input is stalled during that search.
// Results sit in an output register (out_valid/out_stall); while a result
// waits, frame bytes are still taken, and a next result waits in the FSM.
// Reset clears the byte position, the pair count and all control state;
// the table contents need no clearing since only used slots are read.
module packet_header_parser_flow_counter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [5:0]  entry_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [47:0] dest_mac,
    output logic [47:0] source_mac,
    output logic [31:0] source_addr,
    output logic [31:0] dest_addr,
    output logic [15:0] source_port,
    output logic [15:0] dest_port,
    output logic [2:0]  proto_class,
    output logic [31:0] pair_count,
    output logic        table_full,
    output logic        truncated,
    output logic        entry_valid
);

    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_LOOK, S_CMP, S_RDD, S_DONE} state_t;

    state_t state_reg, state_next;
    phfc_pkg::rec_t rec_reg, rec_next;
    phfc_pkg::rec_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    logic [phfc_pkg::TCNT_W-1:0] used_reg, used_next;
    logic [phfc_pkg::TCNT_W-1:0] idx_reg, idx_next;
    logic rd_hit_reg, rd_hit_next;

    logic in_xfer, byte_en, hdr_clear;
    phfc_pkg::hdr_t hdr;
    logic [3:0] ihl_eff;
    logic [phfc_pkg::POS_W-1:0] port_end;

    logic we;
    logic [phfc_pkg::TIDX_W-1:0] waddr, raddr;
    phfc_pkg::pair_t wdata, q;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign byte_en   = in_xfer && !operation;
    assign hdr_clear = (state_reg == S_EVAL);

    phfc_hdr_capture u_cap
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .data_byte (data_byte),
        .clear     (hdr_clear),
        .hdr       (hdr)
    );

    assign raddr = (state_reg == S_IDLE) ? entry_index : idx_reg[phfc_pkg::TIDX_W-1:0];

    phfc_pair_ram u_ram
    (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .q     (q)
    );

    always_comb
    begin
        state_next     = state_reg;
        rec_next       = rec_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        used_next      = used_reg;
        idx_next       = idx_reg;
        rd_hit_next    = rd_hit_reg;
        we             = 1'b0;
        waddr          = idx_reg[phfc_pkg::TIDX_W-1:0];
        wdata          = q;
        ihl_eff        = (hdr.ihl < 4'd5) ? 4'd5 : hdr.ihl;
        port_end       = phfc_pkg::POS_W'(18) + phfc_pkg::POS_W'({ihl_eff, 2'b00});

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (operation)
                    begin
                        rd_hit_next = ({1'b0, entry_index} < used_reg);
                        state_next  = S_RDD;
                    end
                    else if (last_byte)
                    begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_RDD:
            begin
                rec_next = '0;
                if (rd_hit_reg)
                begin
                    rec_next.source_addr = q.src;
                    rec_next.dest_addr   = q.dst;
                    rec_next.pair_count  = q.tally;
                    rec_next.entry_valid = 1'b1;
                end
                state_next = S_DONE;
            end
            S_EVAL:
            begin
                rec_next             = '0;
                rec_next.dest_mac    = hdr.dmac;
                rec_next.source_mac  = hdr.smac;
                rec_next.entry_valid = 1'b1;
                state_next           = S_DONE;
                if (hdr.pos < phfc_pkg::POS_W'(14))
                begin
                    rec_next.truncated = 1'b1;
                end
                else if (hdr.ethertype == phfc_pkg::ETH_IPV4)
                begin
                    if (hdr.pos < phfc_pkg::POS_W'(34))
                    begin
                        rec_next.truncated = 1'b1;
                    end
                    else
                    begin
                        rec_next.source_addr = hdr.saddr;
                        rec_next.dest_addr   = hdr.daddr;
                        case (hdr.proto)
                            phfc_pkg::IP_TCP:  rec_next.proto_class = phfc_pkg::CLS_TCP;
                            phfc_pkg::IP_UDP:  rec_next.proto_class = phfc_pkg::CLS_UDP;
                            phfc_pkg::IP_ICMP: rec_next.proto_class = phfc_pkg::CLS_ICMP;
                            phfc_pkg::IP_IGMP: rec_next.proto_class = phfc_pkg::CLS_IGMP;
                            default:           rec_next.proto_class = phfc_pkg::CLS_OTHER;
                        endcase
                        if (hdr.proto == phfc_pkg::IP_TCP || hdr.proto == phfc_pkg::IP_UDP)
                        begin
                            if (hdr.pos < port_end)
                            begin
                                rec_next.truncated = 1'b1;
                            end
                            else
                            begin
                                // capture already zeroed ports beyond the store
                                rec_next.source_port = hdr.sport;
                                rec_next.dest_port   = hdr.dport;
                            end
                        end
                        idx_next   = '0;
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                if (idx_reg == used_reg)
                begin
                    if (used_reg < phfc_pkg::TCNT_W'(phfc_pkg::TABLE_DEPTH))
                    begin
                        we          = 1'b1;
                        waddr       = used_reg[phfc_pkg::TIDX_W-1:0];
                        wdata.src   = rec_reg.source_addr;
                        wdata.dst   = rec_reg.dest_addr;
                        wdata.tally = 32'd1;
                        used_next   = used_reg + phfc_pkg::TCNT_W'(1);
                        rec_next.pair_count = 32'd1;
                    end
                    else
                    begin
                        rec_next.table_full = 1'b1;
                        rec_next.pair_count = 32'd0;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (q.src == rec_reg.source_addr && q.dst == rec_reg.dest_addr)
                begin
                    we    = 1'b1;
                    wdata = q;
                    if (q.tally != '1)
                        wdata.tally = q.tally + 32'd1;
                    rec_next.pair_count = wdata.tally;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + phfc_pkg::TCNT_W'(1);
                    state_next = S_LOOK;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = rec_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            used_reg      <= '0;
            idx_reg       <= '0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            used_reg      <= used_next;
            idx_reg       <= idx_next;
            rd_hit_reg    <= rd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        out_reg <= out_next;
    end

    assign out_valid   = out_valid_reg;
    assign dest_mac    = out_reg.dest_mac;
    assign source_mac  = out_reg.source_mac;
    assign source_addr = out_reg.source_addr;
    assign dest_addr   = out_reg.dest_addr;
    assign source_port = out_reg.source_port;
    assign dest_port   = out_reg.dest_port;
    assign proto_class = out_reg.proto_class;
    assign pair_count  = out_reg.pair_count;
    assign table_full  = out_reg.table_full;
    assign truncated   = out_reg.truncated;
    assign entry_valid = out_reg.entry_valid;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= phfc_pkg::TCNT_W'(phfc_pkg::TABLE_DEPTH))
        else $error("pair count exceeds table depth");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK || state_reg == S_CMP) |-> idx_reg <= used_reg)
        else $error("search index past used entries");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.table_full) |-> out_reg.pair_count == 32'd0)
        else $error("table full record with nonzero count");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result lost");

endmodule

>>> rtl/core/phfc_pair_ram.sv
// Pair table storage: one write port, one read port with registered data.
// Depends on phfc_pkg.
module phfc_pair_ram
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [phfc_pkg::TIDX_W-1:0] waddr,
    input  phfc_pkg::pair_t             wdata,
    input  logic [phfc_pkg::TIDX_W-1:0] raddr,
    output phfc_pkg::pair_t             q
);

    phfc_pkg::pair_t mem [phfc_pkg::TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q <= mem[raddr];
    end

endmodule

>>> rtl/core/phfc_hdr_capture.sv
// Byte position counter and header field capture as frame bytes arrive.
// Depends on phfc_pkg.
module phfc_hdr_capture
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_en,
    input  logic [7:0]         data_byte,
    input  logic               clear,
    output phfc_pkg::hdr_t     hdr
);

    phfc_pkg::hdr_t hdr_reg;
    phfc_pkg::hdr_t hdr_next;
    logic [3:0]     ihl_eff;
    logic [phfc_pkg::POS_W-1:0] port_off;
    logic [phfc_pkg::POS_W-1:0] p;

    always_comb
    begin
        p        = hdr_reg.pos;
        ihl_eff  = (hdr_reg.ihl < 4'd5) ? 4'd5 : hdr_reg.ihl;
        port_off = phfc_pkg::POS_W'(14) + phfc_pkg::POS_W'({ihl_eff, 2'b00});
        hdr_next = hdr_reg;
        if (clear)
        begin
            hdr_next = '0;
        end
        else if (byte_en)
        begin
            for (int i = 0; i < 6; i++)
            begin
                if (p == phfc_pkg::POS_W'(i))
                    hdr_next.dmac[8*(5-i) +: 8] = data_byte;
                if (p == phfc_pkg::POS_W'(6 + i))
                    hdr_next.smac[8*(5-i) +: 8] = data_byte;
            end
            for (int i = 0; i < 2; i++)
            begin
                if (p == phfc_pkg::POS_W'(12 + i))
                    hdr_next.ethertype[8*(1-i) +: 8] = data_byte;
            end
            if (p == phfc_pkg::POS_W'(14))
                hdr_next.ihl = data_byte[3:0];
            if (p == phfc_pkg::POS_W'(23))
                hdr_next.proto = data_byte;
            for (int i = 0; i < 4; i++)
            begin
                if (p == phfc_pkg::POS_W'(26 + i))
                    hdr_next.saddr[8*(3-i) +: 8] = data_byte;
                if (p == phfc_pkg::POS_W'(30 + i))
                    hdr_next.daddr[8*(3-i) +: 8] = data_byte;
            end
            // ports only when all four bytes fall inside the stored header
            if (port_off + phfc_pkg::POS_W'(4) <= phfc_pkg::POS_W'(phfc_pkg::HEADER_BYTES))
            begin
                for (int i = 0; i < 2; i++)
                begin
                    if (p == port_off + phfc_pkg::POS_W'(i))
                        hdr_next.sport[8*(1-i) +: 8] = data_byte;
                    if (p == port_off + phfc_pkg::POS_W'(2 + i))
                        hdr_next.dport[8*(1-i) +: 8] = data_byte;
                end
            end
            if (p != phfc_pkg::POS_MAX)
                hdr_next.pos = p + phfc_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= '0;
        end
        else
        begin
            hdr_reg <= hdr_next;
        end
    end

    assign hdr = hdr_reg;

endmodule
